// File: rtl/core/arma_residual_loglikelihood_defines.svh
// Assertion macros shared by the ARMA log-likelihood block.
`ifndef ARMA_RESIDUAL_LOGLIKELIHOOD_DEFINES_SVH
`define ARMA_RESIDUAL_LOGLIKELIHOOD_DEFINES_SVH

// Condition in one cycle implies a consequence in the next cycle.
`define ARL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition implies a consequence in the same cycle.
`define ARL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/arl_pkg.sv
// Shared types and constants of the ARMA log-likelihood block.
package arl_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_AR_ORDER   = 3'd0,
    REG_MA_ORDER   = 3'd1,
    REG_MEAN       = 3'd2,
    REG_INV_2SIGSQ = 3'd3,
    REG_HALF_LOGSQ = 3'd4
  } reg_idx_t;

  localparam int TERM_IDX_BITS = 4;

  // operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_TERM,
    MUL_SQ,
    MUL_SH,
    MUL_SL,
    MUL_CNT
  } mul_sel_t;

  // addend selection of the prediction accumulator
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_PROD,
    ACC_MU,
    ACC_RND
  } acc_op_t;

  typedef struct packed {
    logic                     coef_wr;
    logic                     cap_sample;
    logic                     mul_en;
    mul_sel_t                 mul_sel;
    logic                     term_ma;
    logic [TERM_IDX_BITS-1:0] term_idx;
    acc_op_t                  acc_op;
    logic                     calc_resid;
    logic                     upd;
    logic                     sum_add;
    logic                     fin_hi;
    logic                     fin_term1;
    logic                     fin_ll;
  } cmd_t;

  typedef struct packed {
    logic hist_ready;
  } status_t;

  localparam logic signed [65:0] ACC_MAX66 = 66'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] ACC_MIN66 = -66'sh0_8000_0000_0000_0000;
  localparam logic signed [63:0] I32_MAX64 = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] I32_MIN64 = -64'sh8000_0000;
  localparam logic signed [32:0] I32_MAX33 = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] I32_MIN33 = -33'sh0_8000_0000;
  localparam logic signed [66:0] LL_MAX67  = 67'sh7FFF_FFFF_FFFF;
  localparam logic signed [66:0] LL_MIN67  = -67'sh8000_0000_0000;
  localparam logic [64:0]        T1_CLAMP  = 65'h1_0000_0000_0000;
  localparam logic signed [65:0] RND_HALF  = 66'sd32768;

endpackage

// File: rtl/core/arl_ctrl.sv
// Sequencer of the ARMA log-likelihood block: handshakes and datapath commands.
module arl_ctrl
  import arl_pkg::*;
#(
  parameter int MAX_AR = 8,
  parameter int MAX_MA = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              func,
  input  logic                              last,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  input  logic [$clog2(MAX_AR+1)-1:0]       p_eff,
  input  logic [$clog2(MAX_MA+1)-1:0]       q_eff,
  input  status_t                           status,
  output cmd_t                              cmd
);

  localparam int JW = $clog2(MAX_AR + MAX_MA + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_MU, S_RND, S_RES, S_SQ, S_UPD, S_FSH, S_FSL, S_FCNT, S_FOUT
  } state_t;

  state_t          state, state_next;
  logic [JW-1:0]   j, j_next;
  logic [JW-1:0]   n_terms;
  logic [JW-1:0]   p_ext;
  logic            last_q, fit;
  logic            req_acc, can_load;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && (state == S_IDLE);
  assign can_load  = !rsp_valid || !rsp_stall;
  assign p_ext     = JW'(p_eff);
  assign n_terms   = p_ext + JW'(q_eff);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_TERM;
    cmd.acc_op  = ACC_NONE;
    state_next = state;
    j_next     = j;
    unique case (state)
      S_IDLE: begin
        cmd.coef_wr    = req_acc && !func;
        cmd.cap_sample = req_acc && func;
        j_next         = '0;
        if (req_acc && func) begin
          state_next = status.hist_ready ? S_MAC : S_UPD;
        end
      end
      S_MAC: begin
        // issue term j, fold in the product of term j-1
        cmd.mul_en   = (j < n_terms);
        cmd.mul_sel  = MUL_TERM;
        cmd.term_ma  = (j >= p_ext);
        cmd.term_idx = (j >= p_ext) ? TERM_IDX_BITS'(j - p_ext) : TERM_IDX_BITS'(j);
        cmd.acc_op   = (j != '0) ? ACC_PROD : ACC_NONE;
        if (j == n_terms) begin
          state_next = S_MU;
        end else begin
          j_next = j + JW'(1);
        end
      end
      S_MU: begin
        cmd.acc_op = ACC_MU;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.acc_op = ACC_RND;
        state_next = S_RES;
      end
      S_RES: begin
        cmd.calc_resid = 1'b1;
        state_next     = S_SQ;
      end
      S_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ;
        state_next  = S_UPD;
      end
      S_UPD: begin
        cmd.upd     = 1'b1;
        cmd.sum_add = fit;
        state_next  = last_q ? S_FSH : S_IDLE;
      end
      S_FSH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SH;
        state_next  = S_FSL;
      end
      S_FSL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SL;
        cmd.fin_hi  = 1'b1;
        state_next  = S_FCNT;
      end
      S_FCNT: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_CNT;
        cmd.fin_term1 = 1'b1;
        state_next    = S_FOUT;
      end
      S_FOUT: begin
        // wait for the result register to be free
        cmd.fin_ll = can_load;
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      j         <= '0;
      last_q    <= 1'b0;
      fit       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      j     <= j_next;
      if (cmd.cap_sample) begin
        last_q <= last;
        fit    <= status.hist_ready;
      end
      if (cmd.fin_ll) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/arl_dp.sv
// Datapath of the ARMA log-likelihood block: histories, shared multiplier, sums.
module arl_dp
  import arl_pkg::*;
#(
  parameter int MAX_AR     = 8,
  parameter int MAX_MA     = 8,
  parameter int COUNT_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output status_t                      status,
  input  logic [3:0]                   coef_index,
  input  logic signed [31:0]           coef_value,
  input  logic signed [31:0]           sample,
  input  logic [$clog2(MAX_AR+1)-1:0]  p_eff,
  input  logic signed [31:0]           mean_offset,
  input  logic [31:0]                  inv_two_sigma_sq,
  input  logic signed [31:0]           half_log_sigma_sq,
  output logic signed [47:0]           log_likelihood,
  output logic [23:0]                  residual_count,
  output logic                         saturated
);

  localparam int ARW = (MAX_AR > 1) ? $clog2(MAX_AR) : 1;
  localparam int MAW = (MAX_MA > 1) ? $clog2(MAX_MA) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic signed [31:0] ar_coefs [MAX_AR];
  logic signed [31:0] ma_coefs [MAX_MA];
  logic signed [31:0] sample_history [MAX_AR];
  logic signed [31:0] residual_history [MAX_MA];
  logic [COUNT_BITS-1:0] samples_seen;
  logic [63:0]           square_sum;
  logic                  sat_seen, sat_next;

  logic signed [31:0] z_q, resid;
  logic signed [63:0] acc;
  logic signed [65:0] prod;
  logic               prod_neg;
  logic [63:0]        t_hi;
  logic [48:0]        term1;
  logic               t1_sat;

  logic [COUNT_BITS-1:0] p_ext, cnt;
  logic signed [32:0]    mul_a, mul_b;
  logic signed [31:0]    coef_op, hist_op;
  logic signed [65:0]    addend, acc_sum;
  logic signed [63:0]    acc_next;
  logic                  acc_sat;
  logic signed [63:0]    y_full;
  logic signed [31:0]    y32;
  logic signed [32:0]    diff;
  logic signed [31:0]    resid_next;
  logic                  res_sat;
  logic [64:0]           sum_ext;
  logic [64:0]           t1_full;
  logic signed [66:0]    ll_full;
  logic signed [47:0]    ll_sat_val;
  logic                  ll_sat;

  assign p_ext             = COUNT_BITS'(p_eff);
  assign cnt               = (samples_seen > p_ext) ? (samples_seen - p_ext) : '0;
  assign status.hist_ready = (samples_seen >= p_ext);

  // operand selection of the shared multiplier
  assign coef_op = cmd.term_ma ? ma_coefs[cmd.term_idx[MAW-1:0]]
                               : ar_coefs[cmd.term_idx[ARW-1:0]];
  assign hist_op = cmd.term_ma ? residual_history[cmd.term_idx[MAW-1:0]]
                               : sample_history[cmd.term_idx[ARW-1:0]];

  always_comb begin
    case (cmd.mul_sel)
      MUL_TERM: begin
        mul_a = 33'(coef_op);
        mul_b = 33'(hist_op);
      end
      MUL_SQ: begin
        mul_a = 33'(resid);
        mul_b = 33'(resid);
      end
      MUL_SH: begin
        mul_a = $signed({1'b0, square_sum[63:32]});
        mul_b = $signed({1'b0, inv_two_sigma_sq});
      end
      MUL_SL: begin
        mul_a = $signed({1'b0, square_sum[31:0]});
        mul_b = $signed({1'b0, inv_two_sigma_sq});
      end
      MUL_CNT: begin
        mul_a = $signed({1'b0, 32'(cnt)});
        mul_b = 33'(half_log_sigma_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturating prediction accumulator
  always_comb begin
    case (cmd.acc_op)
      ACC_PROD: addend = prod_neg ? -prod : prod;
      ACC_MU:   addend = 66'(mean_offset) <<< 16;
      ACC_RND:  addend = RND_HALF;
      default:  addend = '0;
    endcase
    acc_sum = 66'(acc) + addend;
    acc_sat = 1'b0;
    if (acc_sum > ACC_MAX66) begin
      acc_next = ACC_MAX66[63:0];
      acc_sat  = (cmd.acc_op != ACC_NONE);
    end else if (acc_sum < ACC_MIN66) begin
      acc_next = ACC_MIN66[63:0];
      acc_sat  = (cmd.acc_op != ACC_NONE);
    end else begin
      acc_next = acc_sum[63:0];
    end
  end

  // rounded prediction and residual, both clamped to 32 bits
  always_comb begin
    res_sat = 1'b0;
    y_full  = acc >>> 16;
    if (y_full > I32_MAX64) begin
      y32     = I32_MAX64[31:0];
      res_sat = 1'b1;
    end else if (y_full < I32_MIN64) begin
      y32     = I32_MIN64[31:0];
      res_sat = 1'b1;
    end else begin
      y32 = y_full[31:0];
    end
    diff = 33'(z_q) - 33'(y32);
    if (diff > I32_MAX33) begin
      resid_next = I32_MAX33[31:0];
      res_sat    = 1'b1;
    end else if (diff < I32_MIN33) begin
      resid_next = I32_MIN33[31:0];
      res_sat    = 1'b1;
    end else begin
      resid_next = diff[31:0];
    end
  end

  // final combine: clamp of the sum term, then saturated difference
  assign sum_ext = {1'b0, square_sum} + {1'b0, prod[63:0]};
  assign t1_full = {1'b0, t_hi} + {33'd0, prod[63:32]};

  always_comb begin
    ll_full = -$signed({18'd0, term1}) - 67'(prod);
    ll_sat  = 1'b0;
    if (ll_full > LL_MAX67) begin
      ll_sat_val = LL_MAX67[47:0];
      ll_sat     = 1'b1;
    end else if (ll_full < LL_MIN67) begin
      ll_sat_val = LL_MIN67[47:0];
      ll_sat     = 1'b1;
    end else begin
      ll_sat_val = ll_full[47:0];
    end
  end

  // sticky saturation flag, cleared with the series
  always_comb begin
    sat_next = sat_seen;
    if (acc_sat) sat_next = 1'b1;
    if (cmd.calc_resid && res_sat) sat_next = 1'b1;
    if (cmd.upd && cmd.sum_add && sum_ext[64]) sat_next = 1'b1;
    if (cmd.upd && (samples_seen == CNT_MAX)) sat_next = 1'b1;
    if (cmd.fin_ll) sat_next = 1'b0;
  end

  // series state: coefficients, histories, count, sum
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_AR; i++) begin
        ar_coefs[i]       <= '0;
        sample_history[i] <= '0;
      end
      for (int i = 0; i < MAX_MA; i++) begin
        ma_coefs[i]         <= '0;
        residual_history[i] <= '0;
      end
      samples_seen <= '0;
      square_sum   <= '0;
      sat_seen     <= 1'b0;
    end else begin
      sat_seen <= sat_next;
      if (cmd.coef_wr) begin
        for (int i = 0; i < MAX_AR; i++) begin
          if (!coef_index[3] && ({1'b0, coef_index[2:0]} == 4'(i))) begin
            ar_coefs[i] <= coef_value;
          end
        end
        for (int i = 0; i < MAX_MA; i++) begin
          if (coef_index[3] && ({1'b0, coef_index[2:0]} == 4'(i))) begin
            ma_coefs[i] <= coef_value;
          end
        end
      end
      if (cmd.upd) begin
        for (int i = MAX_AR - 1; i > 0; i--) sample_history[i] <= sample_history[i-1];
        sample_history[0] <= z_q;
        for (int i = MAX_MA - 1; i > 0; i--) residual_history[i] <= residual_history[i-1];
        residual_history[0] <= resid;
        if (samples_seen != CNT_MAX) begin
          samples_seen <= samples_seen + COUNT_BITS'(1);
        end
        if (cmd.sum_add) begin
          square_sum <= sum_ext[64] ? '1 : sum_ext[63:0];
        end
      end
      if (cmd.fin_ll) begin
        for (int i = 0; i < MAX_AR; i++) sample_history[i] <= '0;
        for (int i = 0; i < MAX_MA; i++) residual_history[i] <= '0;
        samples_seen <= '0;
        square_sum   <= '0;
      end
    end
  end

  // working registers and the result register
  always_ff @(posedge clk) begin
    if (cmd.cap_sample) begin
      z_q   <= sample;
      acc   <= '0;
      resid <= '0;
    end else begin
      if (cmd.acc_op != ACC_NONE) acc <= acc_next;
      if (cmd.calc_resid) resid <= resid_next;
    end
    if (cmd.mul_en) begin
      prod     <= mul_a * mul_b;
      prod_neg <= cmd.term_ma;
    end
    if (cmd.fin_hi) t_hi <= prod[63:0];
    if (cmd.fin_term1) begin
      if (t1_full > T1_CLAMP) begin
        term1  <= T1_CLAMP[48:0];
        t1_sat <= 1'b1;
      end else begin
        term1  <= t1_full[48:0];
        t1_sat <= 1'b0;
      end
    end
    if (cmd.fin_ll) begin
      log_likelihood <= ll_sat_val;
      residual_count <= 24'(cnt);
      saturated      <= sat_seen | t1_sat | ll_sat;
    end
  end

endmodule

// File: rtl/core/arma_residual_loglikelihood.sv
// ARMA(p,q) residual log-likelihood engine: top level with configuration registers.
//
// Request channel (req_valid/req_stall): func 0 writes AR/MA coefficient coef_index with
// coef_value; func 1 presents sample z(t), with last marking the end of a series.
// Response channel (rsp_valid/rsp_stall): one item per series, on the sample marked last,
// carrying log_likelihood, residual_count and the saturated flag.
// A coefficient write leaves the block idle. A sample goes straight to the history update
// while fewer than p samples have been seen; else one shared 33x33 multiplier steps
// through the p+q prediction terms one per cycle, then the mean and the rounding constant
// are added and the residual, its square and the history update follow. A last sample adds
// the final multiplies before the result register is loaded. Configuration goes through
// the APB-style port; the user must keep writes to times when the block is idle, as the
// block itself does not enforce it; pready is always 1. Reset clears coefficients, histories,
// count, sum and flags and loads register defaults; the block accepts items as soon as
// reset is released. A stalled response holds in its register; the next series can be
// processed meanwhile, and only its final step waits until the register is free.
module arma_residual_loglikelihood
  import arl_pkg::*;
#(
  parameter int MAX_AR     = 8,
  parameter int MAX_MA     = 8,
  parameter int COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                func,
  input  logic [3:0]          coef_index,
  input  logic signed [31:0]  coef_value,
  input  logic signed [31:0]  sample,
  input  logic                last,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic signed [47:0]  log_likelihood,
  output logic [23:0]         residual_count,
  output logic                saturated
);

`include "arma_residual_loglikelihood_defines.svh"

  localparam int PW = $clog2(MAX_AR + 1);
  localparam int QW = $clog2(MAX_MA + 1);

  logic [3:0]         ar_order, ma_order;
  logic signed [31:0] mean_offset, half_log_sigma_sq;
  logic [31:0]        inv_two_sigma_sq;
  logic [PW-1:0]      p_eff;
  logic [QW-1:0]      q_eff;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  cmd_t               cmd;
  status_t            status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ar_order          <= '0;
      ma_order          <= '0;
      mean_offset       <= '0;
      inv_two_sigma_sq  <= 32'd65536;
      half_log_sigma_sq <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AR_ORDER:   ar_order          <= pwdata[3:0];
        REG_MA_ORDER:   ma_order          <= pwdata[3:0];
        REG_MEAN:       mean_offset       <= pwdata;
        REG_INV_2SIGSQ: inv_two_sigma_sq  <= pwdata;
        REG_HALF_LOGSQ: half_log_sigma_sq <= pwdata;
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_AR_ORDER:   prdata = {28'd0, ar_order};
      REG_MA_ORDER:   prdata = {28'd0, ma_order};
      REG_MEAN:       prdata = mean_offset;
      REG_INV_2SIGSQ: prdata = inv_two_sigma_sq;
      REG_HALF_LOGSQ: prdata = half_log_sigma_sq;
      default:        prdata = '0;
    endcase
  end

  // orders above the coefficient slots count as the full order
  assign p_eff = (32'(ar_order) > MAX_AR) ? PW'(MAX_AR) : PW'(ar_order);
  assign q_eff = (32'(ma_order) > MAX_MA) ? QW'(MAX_MA) : QW'(ma_order);

  arl_ctrl #(
    .MAX_AR (MAX_AR),
    .MAX_MA (MAX_MA)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .last      (last),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .p_eff     (p_eff),
    .q_eff     (q_eff),
    .status    (status),
    .cmd       (cmd)
  );

  arl_dp #(
    .MAX_AR     (MAX_AR),
    .MAX_MA     (MAX_MA),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .coef_index        (coef_index),
    .coef_value        (coef_value),
    .sample            (sample),
    .p_eff             (p_eff),
    .mean_offset       (mean_offset),
    .inv_two_sigma_sq  (inv_two_sigma_sq),
    .half_log_sigma_sq (half_log_sigma_sq),
    .log_likelihood    (log_likelihood),
    .residual_count    (residual_count),
    .saturated         (saturated)
  );

  // an accepted sample leaves the block busy
  `ARL_ASSERT_NEXT(a_sample_busy, req_valid && !req_stall && func, req_stall,
                   "accepted sample did not occupy the sequencer")
  // a coefficient write never produces a response
  `ARL_ASSERT_NEXT(a_coef_no_rsp, req_valid && !req_stall && !func, !$rose(rsp_valid),
                   "response raised after a coefficient write")
  // a response is only loaded from the final step, never from idle
  `ARL_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall),
                  "response raised while the sequencer was idle")

endmodule

// File: sim/arma_residual_loglikelihood_tb.sv
// Self-checking testbench for the ARMA residual log-likelihood engine.
module arma_residual_loglikelihood_tb;
  import arl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ORDER    = 8;
  localparam int MA_BASE      = 8;
  // longest sample (p = q = 8) plus the final multiplies, with margin
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic {
    FN_COEF   = 1'b0,
    FN_SAMPLE = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] sample;
    logic               last;
  } arma_req_t;

  typedef struct packed {
    logic signed [47:0] ll;
    logic [23:0]        count;
    logic               sat;
  } loglik_t;

  // clock, reset and block ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               func = 1'b0;
  logic [3:0]         coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] sample = '0;
  logic               last = 1'b0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [47:0] log_likelihood;
  logic [23:0]        residual_count;
  logic               saturated;

  // stimulus and scoreboard
  arma_req_t arma_requests[$];
  loglik_t   loglik_expected[$];
  arma_req_t next_req;
  logic      req_taken = 1'b0;
  int        queued_count = 0;
  int        accepted_count = 0;
  int        results_checked = 0;
  int        reg_writes = 0;
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  // predictor state: registers, coefficients and the running series
  logic [3:0]         ar_order_m;
  logic [3:0]         ma_order_m;
  logic signed [31:0] mu_m;
  logic [31:0]        inv_m;
  logic signed [31:0] half_m;
  logic signed [31:0] ar_coef_m[MAX_ORDER];
  logic signed [31:0] ma_coef_m[MAX_ORDER];
  logic signed [31:0] z_hist_m[MAX_ORDER];
  logic signed [31:0] e_hist_m[MAX_ORDER];
  logic [23:0]        seen_m;
  logic [63:0]        sum_m;
  logic               sat_m;

  arma_residual_loglikelihood dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .func           (func),
    .coef_index     (coef_index),
    .coef_value     (coef_value),
    .sample         (sample),
    .last           (last),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .log_likelihood (log_likelihood),
    .residual_count (residual_count),
    .saturated      (saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // saturating add of the Q32.32 prediction accumulator
  function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      sat_m = 1'b1;
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clamp_q16(input logic signed [63:0] x);
    if (x > I32_MAX64) begin
      sat_m = 1'b1;
      return {1'b0, {31{1'b1}}};
    end
    if (x < I32_MIN64) begin
      sat_m = 1'b1;
      return {1'b1, 31'd0};
    end
    return x[31:0];
  endfunction

  function automatic void clear_series();
    int j;
    for (j = 0; j < MAX_ORDER; j++) begin
      z_hist_m[j] = '0;
      e_hist_m[j] = '0;
    end
    seen_m = '0;
    sum_m  = '0;
    sat_m  = 1'b0;
  endfunction

  // apply one accepted item; a last sample queues the expected log likelihood
  function automatic void arma_apply(input arma_req_t r);
    int                 j;
    logic [3:0]         p;
    logic [3:0]         q;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] e;
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [63:0] diff;
    logic [63:0]        sq;
    logic [64:0]        sum_next;
    logic [23:0]        cnt;
    logic [63:0]        hi_prod;
    logic [63:0]        lo_prod;
    logic [64:0]        t1;
    logic signed [63:0] t1s;
    logic signed [63:0] cnt_s;
    logic signed [63:0] term2;
    logic signed [63:0] ll;
    loglik_t            res;
    if (r.func == FN_COEF) begin
      if (r.coef_index < MA_BASE) ar_coef_m[r.coef_index[2:0]] = r.coef_value;
      else ma_coef_m[r.coef_index[2:0]] = r.coef_value;
      return;
    end
    p = (ar_order_m > MAX_ORDER) ? 4'(MAX_ORDER) : ar_order_m;
    q = (ma_order_m > MAX_ORDER) ? 4'(MAX_ORDER) : ma_order_m;
    z = r.sample;
    e = '0;
    // prediction and residual once p samples are in the history
    if (seen_m >= p) begin
      acc = '0;
      for (j = 0; j < MAX_ORDER; j++) begin
        if (j < p) begin
          prod = ar_coef_m[j] * z_hist_m[j];
          acc  = acc_add(acc, prod);
        end
      end
      for (j = 0; j < MAX_ORDER; j++) begin
        if (j < q) begin
          prod = ma_coef_m[j] * e_hist_m[j];
          acc  = acc_add(acc, -prod);
        end
      end
      acc  = acc_add(acc, {{16{mu_m[31]}}, mu_m, 16'd0});
      acc  = acc_add(acc, 64'sd32768);
      y    = clamp_q16(acc >>> 16);
      diff = z - y;
      e    = clamp_q16(diff);
      sq   = e * e;
      sum_next = {1'b0, sum_m} + {1'b0, sq};
      if (sum_next[64]) begin
        sum_m = '1;
        sat_m = 1'b1;
      end else begin
        sum_m = sum_next[63:0];
      end
    end
    for (j = MAX_ORDER - 1; j > 0; j--) begin
      z_hist_m[j] = z_hist_m[j-1];
      e_hist_m[j] = e_hist_m[j-1];
    end
    z_hist_m[0] = z;
    e_hist_m[0] = e;
    if (seen_m == '1) sat_m = 1'b1;
    else seen_m = seen_m + 1'b1;
    if (!r.last) return;

    // end of series: -sum/(2 sigma^2) - count*log term
    res.sat = sat_m;
    cnt     = (seen_m > p) ? seen_m - p : '0;
    hi_prod = sum_m[63:32] * inv_m;
    lo_prod = sum_m[31:0] * inv_m;
    t1      = {1'b0, hi_prod} + {33'd0, lo_prod[63:32]};
    if (t1 > T1_CLAMP) begin
      t1      = T1_CLAMP;
      res.sat = 1'b1;
    end
    t1s   = t1[63:0];
    cnt_s = {40'd0, cnt};
    term2 = cnt_s * half_m;
    ll    = -t1s - term2;
    if (ll > LL_MAX67) begin
      ll      = LL_MAX67[63:0];
      res.sat = 1'b1;
    end
    if (ll < LL_MIN67) begin
      ll      = LL_MIN67[63:0];
      res.sat = 1'b1;
    end
    res.ll    = ll[47:0];
    res.count = cnt;
    loglik_expected.push_back(res);
    clear_series();
  endfunction

  // request driver: next item at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (arma_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = arma_requests.pop_front();
        req_valid  <= 1'b1;
        func       <= next_req.func;
        coef_index <= next_req.coef_index;
        coef_value <= next_req.coef_value;
        sample     <= next_req.sample;
        last       <= next_req.last;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response backpressure
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        accepted_count++;
        arma_apply('{func_t'(func), coef_index, coef_value, sample, last});
      end
      if (rsp_valid && !rsp_stall) begin
        if (loglik_expected.size() == 0) begin
          $error("result with none expected: log_likelihood %0d count %0d",
                 log_likelihood, residual_count);
          error_count++;
        end else begin
          loglik_t exp_res;
          exp_res = loglik_expected.pop_front();
          results_checked++;
          if (log_likelihood !== exp_res.ll) begin
            $error("log_likelihood: expected %0d, got %0d", exp_res.ll, log_likelihood);
            error_count++;
          end
          if (residual_count !== exp_res.count) begin
            $error("residual_count: expected %0d, got %0d", exp_res.count, residual_count);
            error_count++;
          end
          if (saturated !== exp_res.sat) begin
            $error("saturated: expected %0b, got %0b", exp_res.sat, saturated);
            error_count++;
          end
        end
      end
    end
  end

  // register write over the configuration port, mirrored in the predictor
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_AR_ORDER:   ar_order_m = data[3:0];
      REG_MA_ORDER:   ma_order_m = data[3:0];
      REG_MEAN:       mu_m       = data;
      REG_INV_2SIGSQ: inv_m      = data;
      REG_HALF_LOGSQ: half_m     = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(input logic [3:0] ar, input logic [3:0] ma, input logic [31:0] mu,
                           input logic [31:0] inv, input logic [31:0] half);
    reg_write(REG_AR_ORDER, {28'd0, ar});
    reg_write(REG_MA_ORDER, {28'd0, ma});
    reg_write(REG_MEAN, mu);
    reg_write(REG_INV_2SIGSQ, inv);
    reg_write(REG_HALF_LOGSQ, half);
  endtask

  // all items taken, all results back, then let a pending sample finish
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != queued_count || loglik_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void push_coef(input logic [3:0] idx, input logic [31:0] val,
                                    input logic lst);
    arma_req_t r;
    r.func       = FN_COEF;
    r.coef_index = idx;
    r.coef_value = val;
    r.sample     = $urandom;
    r.last       = lst;
    arma_requests.push_back(r);
    queued_count++;
  endfunction

  function automatic void push_sample(input logic [31:0] z, input logic lst);
    arma_req_t r;
    r.func       = FN_SAMPLE;
    r.coef_index = 4'($urandom_range(15));
    r.coef_value = $urandom;
    r.sample     = z;
    r.last       = lst;
    arma_requests.push_back(r);
    queued_count++;
  endfunction

  // mostly values within +/-span, now and then any 32-bit word
  function automatic logic [31:0] rand_q16(input int span);
    int v;
    if ($urandom_range(9) == 0) return $urandom;
    v = $urandom_range(0, 2 * span);
    return v - span;
  endfunction

  initial begin
    int          phase;
    int          round;
    int          series_left;
    int          k;
    logic [3:0]  ar;
    logic [3:0]  ma;
    logic [31:0] mu;
    logic [31:0] inv;
    logic [31:0] half;

    // predictor reset state
    ar_order_m = '0;
    ma_order_m = '0;
    mu_m       = '0;
    inv_m      = 32'd65536;
    half_m     = '0;
    for (k = 0; k < MAX_ORDER; k++) begin
      ar_coef_m[k] = '0;
      ma_coef_m[k] = '0;
    end
    clear_series();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: coefficient writes ignore last; extremes under reset settings
    push_coef(4'd0, 32'h7FFF_FFFF, 1'b1);
    push_coef(4'd7, 32'h8000_0000, 1'b0);
    push_coef(4'd8, 32'h8000_0000, 1'b0);
    push_coef(4'd15, 32'hFFFF_FFFF, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);
    wait_idle();

    // short series, then accumulator and result saturation
    write_all(4'd2, 4'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);

    // orders raised above the maximum in the middle of a series
    push_coef(4'd1, 32'h0001_0000, 1'b0);
    push_coef(4'd9, 32'h0000_8000, 1'b0);
    push_sample(32'h0003_0000, 1'b0);
    push_sample(32'hFFFE_0000, 1'b0);
    wait_idle();
    reg_write(REG_AR_ORDER, 32'd9);
    reg_write(REG_MA_ORDER, 32'd12);
    push_sample(32'h0001_8000, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_0000, 1'b1);
    wait_idle();

    // log term alone, at both extremes
    write_all(4'd0, 4'd0, 32'h0, 32'd65536, 32'h7FFF_FFFF);
    push_sample(32'h0, 1'b1);
    push_sample(32'h0, 1'b0);
    push_sample(32'h0, 1'b1);
    wait_idle();
    reg_write(REG_HALF_LOGSQ, 32'h8000_0000);
    push_sample(32'h0, 1'b0);
    push_sample(32'h0, 1'b1);
    wait_idle();

    // random part: fresh small coefficients, then series under varied settings
    for (k = 0; k < 16; k++) push_coef(k[3:0], rand_q16(16384), 1'b0);
    series_left = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (round = 0; round < 8; round++) begin
        wait_idle();
        case (round)
          0: begin ar = 4'd8;  ma = 4'd8;  end
          1: begin ar = 4'd15; ma = 4'd15; end
          2: begin ar = 4'd0;  ma = 4'd0;  end
          default: begin
            ar = ($urandom_range(3) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
            ma = ($urandom_range(3) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
          end
        endcase
        case ($urandom_range(4))
          0: mu = 32'h0;
          1: mu = 32'h7FFF_FFFF;
          2: mu = 32'h8000_0000;
          3: mu = rand_q16(1 << 18);
          default: mu = $urandom;
        endcase
        case ($urandom_range(3))
          0: inv = 32'h0;
          1: inv = 32'hFFFF_FFFF;
          2: inv = 32'd65536;
          default: inv = $urandom_range(0, 1 << 18);
        endcase
        case ($urandom_range(3))
          0: half = 32'h7FFF_FFFF;
          1: half = 32'h8000_0000;
          2: half = rand_q16(1 << 17);
          default: half = $urandom;
        endcase
        write_all(ar, ma, mu, inv, half);
        // an open series carries over the write: orders change mid-series
        repeat (50) begin
          if ($urandom_range(7) == 0) begin
            push_coef(4'($urandom_range(15)), rand_q16(1 << 15), 1'($urandom_range(1)));
          end else begin
            if (series_left == 0) series_left = $urandom_range(1, 16);
            series_left--;
            push_sample(rand_q16(1 << 20), series_left == 0);
          end
        end
      end
    end

    wait_idle();
    $display("%0d items accepted (coefficient writes and samples), %0d register writes",
             accepted_count, reg_writes);
    $display("%0d series results checked across four idle/stall mixes", results_checked);
    if (error_count == 0) begin
      $display("arma_residual_loglikelihood_tb: clean");
    end else begin
      $display("arma_residual_loglikelihood_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(10_000_000);
    $display("arma_residual_loglikelihood_tb: errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/arl_pkg.sv
rtl/core/arl_ctrl.sv
rtl/core/arl_dp.sv
rtl/core/arma_residual_loglikelihood.sv
sim/arma_residual_loglikelihood_tb.sv
